[design/sfrr_pkg.sv]
// Package for the stuffed-frame request receiver.
// Holds payload types, reply codes and request constants.
// No dependencies; every other design file uses it.
package sfrr_pkg;

    localparam int unsigned MAX_FRAME = 299;
    localparam int unsigned MIN_FRAME = 9;
    localparam int unsigned POS_W     = 9;

    localparam logic [POS_W-1:0] POS_KIND    = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CODE_LO = POS_W'(6);
    localparam logic [POS_W-1:0] POS_CODE_HI = POS_W'(7);
    localparam logic [POS_W-1:0] POS_SAT     = '1;

    localparam logic [7:0] KIND_CONTROL = 8'h63;
    localparam logic [7:0] KIND_READ    = 8'h62;
    localparam logic [7:0] CODE_SET_TIME  = 8'h47;
    localparam logic [7:0] CODE_SET_STATE = 8'h5E;
    localparam logic [7:0] CODE_EXCLUDED  = 8'h50;
    localparam logic [7:0] STATE_CLOSE  = 8'h00;
    localparam logic [7:0] STATE_OPEN   = 8'h04;

    localparam logic [15:0] REQ_CYCLIC = 16'h044A;
    localparam logic [15:0] REQ_INFO   = 16'h084A;
    localparam logic [15:0] REQ_STATUS = 16'h0353;

    localparam logic [3:0] STARTUP_RELEASE = 4'd8;
    localparam logic [3:0] STARTUP_MAX     = 4'd15;

    typedef enum logic [2:0] {
        REPLY_NONE   = 3'd0,
        REPLY_ACK    = 3'd1,
        REPLY_CYCLIC = 3'd2,
        REPLY_INFO   = 3'd3,
        REPLY_STATUS = 3'd4
    } reply_kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_enable;
        logic       content_ready;
        logic       close_timer_busy;
    } sfrr_in_t;

    typedef struct packed {
        logic        frame_ok;
        reply_kind_t reply_kind;
        logic        close_timer_start;
        logic        contactor_open;
        logic        startup_timer_start;
        logic [3:0]  startup_frames;
    } sfrr_out_t;

endpackage

[design/sfrr_if.sv]
// Valid/ready channel interfaces for the stuffed-frame request receiver.
// Depends on sfrr_pkg for the payload types.
interface sfrr_in_if;
    logic               valid;
    logic               ready;
    sfrr_pkg::sfrr_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sfrr_out_if;
    logic                valid;
    logic                ready;
    sfrr_pkg::sfrr_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[design/stuffed_frame_request_receiver_top.sv]
// Stuffed-frame request receiver, top level.
// Depends on sfrr_pkg and the channel interfaces in sfrr_if.sv.
//
// Takes one received byte per transaction and can accept a byte in every cycle.
// Each byte waits in an input register, where the stuffed-zero
// decode, running checksum and request decode update the frame state; a frame
// end that passes the length and content-ready checks loads one result into the
// output register, one register behind the input register that took its closing zero byte.
// Input and result registers decouple the two sides: a byte is still taken
// while a result waits, and only a frame end that meets a full, stalled result
// register holds the input. Bytes with rx_enable low leave no trace.
module stuffed_frame_request_receiver_top
(
    input  logic              clk,
    input  logic              rst_n,
    sfrr_in_if.sink           items,
    sfrr_out_if.source        results
);

    localparam int unsigned PW = sfrr_pkg::POS_W;

    logic                in_valid_reg;
    sfrr_pkg::sfrr_in_t  in_reg;
    logic                res_valid_reg;
    logic                res_valid_next;
    sfrr_pkg::sfrr_out_t res_reg;
    sfrr_pkg::sfrr_out_t res_next;

    logic [PW-1:0] byte_count_reg, byte_count_next;
    logic [PW-1:0] next_zero_reg, next_zero_next;
    logic [7:0]    sum_reg, sum_next;
    logic [7:0]    lag_raw_reg, lag_raw_next;
    logic [7:0]    lag_dec_reg, lag_dec_next;
    logic [7:0]    kind_reg, kind_next;
    logic [7:0]    code_lo_reg, code_lo_next;
    logic [7:0]    code_hi_reg, code_hi_next;
    logic          info_done_reg, info_done_next;
    logic [3:0]    startup_cnt_reg, startup_cnt_next;
    logic          close_pend_reg, close_pend_next;
    logic          startup_seen_reg, startup_seen_next;

    logic          frame_end;
    logic          res_free;
    logic          advance;

    assign frame_end = in_reg.rx_enable && (in_reg.rx_byte == 8'd0)
                       && (byte_count_reg >= PW'(sfrr_pkg::MIN_FRAME))
                       && in_reg.content_ready;
    assign res_free  = !res_valid_reg || results.ready;
    assign advance   = in_valid_reg && (!frame_end || res_free);

    assign items.ready   = !in_valid_reg || advance;
    assign results.valid = res_valid_reg;
    assign results.data  = res_reg;

    // Frame state update for the byte in the input register
    always_comb
    begin
        logic [PW-1:0] p;
        logic [PW:0]   p_inc;
        logic [PW:0]   nz;
        logic [7:0]    d;
        logic [7:0]    hi;
        logic [15:0]   code;
        logic          ok;

        p     = byte_count_reg;
        p_inc = {1'b0, p} + (PW+1)'(1);
        nz    = {1'b0, p} + (PW+1)'(in_reg.rx_byte);
        d     = in_reg.rx_byte;
        hi    = code_hi_reg;
        code  = 16'd0;
        ok    = 1'b0;

        byte_count_next   = byte_count_reg;
        next_zero_next    = next_zero_reg;
        sum_next          = sum_reg;
        lag_raw_next      = lag_raw_reg;
        lag_dec_next      = lag_dec_reg;
        kind_next         = kind_reg;
        code_lo_next      = code_lo_reg;
        code_hi_next      = code_hi_reg;
        info_done_next    = info_done_reg;
        startup_cnt_next  = startup_cnt_reg;
        close_pend_next   = close_pend_reg;
        startup_seen_next = startup_seen_reg;

        res_next                     = '0;
        res_next.reply_kind          = sfrr_pkg::REPLY_NONE;

        if (advance && in_reg.rx_enable)
        begin
            if (in_reg.rx_byte != 8'd0)
            begin
                if (p == '0)
                begin
                    next_zero_next = PW'(in_reg.rx_byte);
                    sum_next       = 8'd0;
                    lag_raw_next   = in_reg.rx_byte;
                    lag_dec_next   = 8'd0;
                end
                else
                begin
                    // stuffed zero: byte is the distance to the next one
                    if (p == next_zero_reg)
                    begin
                        d              = 8'd0;
                        next_zero_next = nz[PW] ? sfrr_pkg::POS_SAT : nz[PW-1:0];
                    end
                    sum_next     = sum_reg + lag_dec_reg;
                    lag_raw_next = in_reg.rx_byte;
                    lag_dec_next = d;
                    if (p == sfrr_pkg::POS_KIND)
                    begin
                        kind_next = d;
                    end
                    if (p == sfrr_pkg::POS_CODE_LO)
                    begin
                        code_lo_next = d;
                    end
                    if (p == sfrr_pkg::POS_CODE_HI)
                    begin
                        code_hi_next = d;
                    end
                end
                byte_count_next = (p_inc >= (PW+1)'(sfrr_pkg::MAX_FRAME)) ? '0
                                                                          : p_inc[PW-1:0];
            end
            else
            begin
                byte_count_next = '0;
                if (frame_end)
                begin
                    ok = ((8'd0 - sum_reg) == lag_raw_reg);
                    // check byte sits at the high code position
                    if (p == sfrr_pkg::POS_CODE_HI + PW'(1))
                    begin
                        hi = lag_raw_reg;
                    end
                    code = {hi, code_lo_reg};
                    if (ok)
                    begin
                        if (kind_reg == sfrr_pkg::KIND_CONTROL && info_done_reg)
                        begin
                            if (code_lo_reg == sfrr_pkg::CODE_SET_TIME)
                            begin
                                res_next.reply_kind = sfrr_pkg::REPLY_ACK;
                            end
                            else if (code_lo_reg == sfrr_pkg::CODE_SET_STATE)
                            begin
                                res_next.reply_kind = sfrr_pkg::REPLY_ACK;
                                if (hi == sfrr_pkg::STATE_CLOSE)
                                begin
                                    if (startup_cnt_reg > sfrr_pkg::STARTUP_RELEASE)
                                    begin
                                        res_next.close_timer_start =
                                            !in_reg.close_timer_busy;
                                    end
                                    else
                                    begin
                                        close_pend_next = 1'b1;
                                    end
                                end
                                else if (hi == sfrr_pkg::STATE_OPEN)
                                begin
                                    res_next.contactor_open = 1'b1;
                                end
                            end
                        end
                        else if (kind_reg == sfrr_pkg::KIND_READ
                                 && code_lo_reg != sfrr_pkg::CODE_EXCLUDED)
                        begin
                            if (code == sfrr_pkg::REQ_CYCLIC && info_done_reg)
                            begin
                                res_next.reply_kind = sfrr_pkg::REPLY_CYCLIC;
                                if (startup_cnt_reg != sfrr_pkg::STARTUP_MAX)
                                begin
                                    startup_cnt_next = startup_cnt_reg + 4'd1;
                                end
                                if (startup_cnt_next == sfrr_pkg::STARTUP_RELEASE
                                    && close_pend_reg && !in_reg.close_timer_busy)
                                begin
                                    res_next.close_timer_start = 1'b1;
                                    close_pend_next            = 1'b0;
                                end
                            end
                            else if (code == sfrr_pkg::REQ_INFO)
                            begin
                                res_next.reply_kind = sfrr_pkg::REPLY_INFO;
                                startup_cnt_next    = 4'd0;
                                close_pend_next     = 1'b0;
                                info_done_next      = 1'b1;
                                startup_seen_next   = 1'b1;
                                res_next.startup_timer_start = !startup_seen_reg;
                            end
                            else if (code == sfrr_pkg::REQ_STATUS && info_done_reg)
                            begin
                                res_next.reply_kind = sfrr_pkg::REPLY_STATUS;
                            end
                        end
                    end
                end
            end
        end

        res_next.frame_ok       = ok;
        res_next.startup_frames = startup_cnt_next;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance && frame_end)
        begin
            res_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            byte_count_reg   <= '0;
            next_zero_reg    <= '0;
            sum_reg          <= '0;
            lag_raw_reg      <= '0;
            lag_dec_reg      <= '0;
            kind_reg         <= '0;
            code_lo_reg      <= '0;
            code_hi_reg      <= '0;
            info_done_reg    <= 1'b0;
            startup_cnt_reg  <= '0;
            close_pend_reg   <= 1'b0;
            startup_seen_reg <= 1'b0;
        end
        else
        begin
            if (items.ready)
            begin
                in_valid_reg <= items.valid;
            end
            res_valid_reg    <= res_valid_next;
            byte_count_reg   <= byte_count_next;
            next_zero_reg    <= next_zero_next;
            sum_reg          <= sum_next;
            lag_raw_reg      <= lag_raw_next;
            lag_dec_reg      <= lag_dec_next;
            kind_reg         <= kind_next;
            code_lo_reg      <= code_lo_next;
            code_hi_reg      <= code_hi_next;
            info_done_reg    <= info_done_next;
            startup_cnt_reg  <= startup_cnt_next;
            close_pend_reg   <= close_pend_next;
            startup_seen_reg <= startup_seen_next;
        end
    end

    // Payload registers: hold the transaction until it moves on
    always_ff @(posedge clk)
    begin
        if (items.ready && items.valid)
        begin
            in_reg <= items.data;
        end
        if (advance && frame_end)
        begin
            res_reg <= res_next;
        end
    end

    a_reply_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_reg.frame_ok || res_reg.reply_kind == sfrr_pkg::REPLY_NONE))
        else $error("reply issued for a frame with a bad checksum");

    a_close_with_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.close_timer_start) |->
        (res_reg.reply_kind == sfrr_pkg::REPLY_ACK
         || res_reg.reply_kind == sfrr_pkg::REPLY_CYCLIC))
        else $error("close timer start without a set-state or cyclic reply");

    a_startup_on_info: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_reg.startup_timer_start) |->
        (res_reg.reply_kind == sfrr_pkg::REPLY_INFO && res_reg.startup_frames == 4'd0))
        else $error("startup timer start outside an info reply");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        byte_count_reg < PW'(sfrr_pkg::MAX_FRAME))
        else $error("byte count past the frame limit");

    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        startup_seen_reg |=> startup_seen_reg)
        else $error("startup seen flag cleared");

endmodule
